### hw/rtl/fifo_thread_scheduler_assert.svh
// Assertion macros for the thread scheduler.
`ifndef FIFO_THREAD_SCHEDULER_ASSERT_SVH
`define FIFO_THREAD_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fts_pkg.sv
package fts_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_RESOLVED,
        ST_SCAN,
        ST_APPEND,
        ST_LINK_TAIL,
        ST_UNLINK_RD,
        ST_UNLINK_DATA,
        ST_FIX_NEXT,
        ST_FIX_PREV,
        ST_DROP,
        ST_FREE,
        ST_DONE
    } t_state;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_YIELD  = 2'd1;
    localparam logic [1:0] KIND_EXIT   = 2'd2;

    localparam logic [1:0] MODE_ANY    = 2'd0;
    localparam logic [1:0] MODE_SELF   = 2'd1;
    localparam logic [1:0] MODE_NAMED  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NONE    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;
    localparam logic [1:0] STAT_NOFREE  = 2'd3;

    localparam int ID_BITS = 10;

endpackage

### hw/rtl/fifo_thread_scheduler.sv
// FIFO ready-queue thread scheduler.
// Input channel s_axis carries one command item: create, yield or exit, with a
// target mode (queue head, self, named id) and a named id. Output channel
// m_axis returns one item per command: status, the id acted on, and the
// running id after the command.
// All per-id state (in-use mark, queued mark, next and prev links) lives in
// one synchronous memory, one entry per id, with a registered read port;
// head, tail, count and running id are flops. Each command is a short
// sequence of reads and masked field writes on that memory.
// A create scans upward from id 1 for the lowest free id, and a named id
// that is not running needs its queued mark read first. One command is in
// flight at a time; the next item is accepted only once the previous
// result has been written to the output register.
// After reset a clearing pass writes every entry, with s_axis_tready low.
// Running id starts at 0, queue empty.
// A finished result sits in an output register; the next command is accepted
// while it waits, and that command's result holds until m_axis_tready frees it.
module fifo_thread_scheduler #(
    parameter int MAX_THREADS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] kind, [3:2] target_mode, [13:4] target_id, [15:14] zero
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [11:2] result_id, [21:12] running_id, [23:22] zero
    output logic [23:0] m_axis_tdata
);

    localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int IDB = fts_pkg::ID_BITS;

    typedef struct packed {
        logic          in_use;
        logic          in_q;
        logic [IW-1:0] nxt;
        logic [IW-1:0] prv;
    } t_entry;

    typedef struct packed {
        logic in_use;
        logic in_q;
        logic nxt;
        logic prv;
    } t_wen;

    t_entry mem [MAX_THREADS];
    t_entry r_rd;

    fts_pkg::t_state r_state, n_state;

    logic [IW-1:0]  r_clr, n_clr;
    logic [1:0]     r_kind, r_mode;
    logic [IDB-1:0] r_named;
    logic [IW-1:0]  r_tgt, n_tgt;
    logic [IW-1:0]  r_rid, n_rid;
    logic [IW-1:0]  r_scan, n_scan;
    logic [IW-1:0]  r_head, n_head;
    logic [IW-1:0]  r_tail, n_tail;
    logic [IW:0]    r_count, n_count;
    logic [IW-1:0]  r_running, n_running;
    logic [IW-1:0]  r_old_tail, n_old_tail;
    logic           r_link, n_link;
    logic [IW-1:0]  r_app_id, n_app_id;
    logic           r_self, n_self;
    logic [IW-1:0]  r_p, n_p;
    logic [IW-1:0]  r_n, n_n;
    logic [1:0]     r_status, n_status;
    logic           r_ov, n_ov;
    logic [23:0]    r_odata, n_odata;

    logic           accept;
    logic           named_ok;
    logic           named_run;
    logic [IW-1:0]  named_id;
    logic           wr_any;
    t_wen           wr_en;
    logic [IW-1:0]  wr_addr;
    t_entry         wr_data;
    logic [IW-1:0]  rd_addr;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign named_ok  = 32'(r_named) < MAX_THREADS;
    assign named_id  = IW'(r_named);
    assign named_run = 32'(r_named) == 32'(r_running);
    assign wr_any    = wr_en.in_use | wr_en.in_q | wr_en.nxt | wr_en.prv;

    // per-entry state memory, masked field writes
    always_ff @(posedge i_clk) begin
        if (wr_any) begin
            if (wr_en.in_use) mem[wr_addr].in_use <= wr_data.in_use;
            if (wr_en.in_q)   mem[wr_addr].in_q   <= wr_data.in_q;
            if (wr_en.nxt)    mem[wr_addr].nxt    <= wr_data.nxt;
            if (wr_en.prv)    mem[wr_addr].prv    <= wr_data.prv;
        end
        r_rd <= mem[rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fts_pkg::ST_CLEAR: begin
                if (32'(r_clr) == MAX_THREADS - 1) n_state = fts_pkg::ST_IDLE;
            end
            fts_pkg::ST_IDLE: begin
                if (accept) n_state = fts_pkg::ST_DISPATCH;
            end
            fts_pkg::ST_DISPATCH: begin
                n_state = fts_pkg::ST_DONE;
                if (r_kind == fts_pkg::KIND_CREATE) begin
                    n_state = fts_pkg::ST_SCAN;
                end else if (r_kind == fts_pkg::KIND_YIELD || r_kind == fts_pkg::KIND_EXIT) begin
                    case (r_mode)
                        fts_pkg::MODE_ANY: begin
                            if (r_count != '0) n_state = fts_pkg::ST_RESOLVED;
                        end
                        fts_pkg::MODE_SELF:  n_state = fts_pkg::ST_RESOLVED;
                        fts_pkg::MODE_NAMED: begin
                            if (named_ok && named_run) n_state = fts_pkg::ST_RESOLVED;
                            else if (named_ok)         n_state = fts_pkg::ST_CHECK;
                        end
                        default: n_state = fts_pkg::ST_DONE;
                    endcase
                end
            end
            fts_pkg::ST_CHECK: begin
                n_state = r_rd.in_q ? fts_pkg::ST_RESOLVED : fts_pkg::ST_DONE;
            end
            fts_pkg::ST_RESOLVED: begin
                if (r_tgt == r_running) begin
                    if (r_kind == fts_pkg::KIND_EXIT && r_count != '0)
                        n_state = fts_pkg::ST_UNLINK_RD;
                    else
                        n_state = fts_pkg::ST_DONE;
                end else if (r_kind == fts_pkg::KIND_YIELD) begin
                    n_state = fts_pkg::ST_APPEND;
                end else begin
                    n_state = fts_pkg::ST_UNLINK_RD;
                end
            end
            fts_pkg::ST_SCAN: begin
                if (!r_rd.in_use)
                    n_state = fts_pkg::ST_APPEND;
                else if (32'(r_scan) == MAX_THREADS - 1)
                    n_state = fts_pkg::ST_DONE;
            end
            fts_pkg::ST_APPEND:    n_state = fts_pkg::ST_LINK_TAIL;
            fts_pkg::ST_LINK_TAIL: begin
                n_state = (r_kind == fts_pkg::KIND_CREATE) ? fts_pkg::ST_DONE
                                                           : fts_pkg::ST_UNLINK_RD;
            end
            fts_pkg::ST_UNLINK_RD:   n_state = fts_pkg::ST_UNLINK_DATA;
            fts_pkg::ST_UNLINK_DATA: n_state = fts_pkg::ST_FIX_NEXT;
            fts_pkg::ST_FIX_NEXT:    n_state = fts_pkg::ST_FIX_PREV;
            fts_pkg::ST_FIX_PREV:    n_state = fts_pkg::ST_DROP;
            fts_pkg::ST_DROP: begin
                n_state = (r_kind == fts_pkg::KIND_EXIT && r_self) ? fts_pkg::ST_FREE
                                                                   : fts_pkg::ST_DONE;
            end
            fts_pkg::ST_FREE: n_state = fts_pkg::ST_DONE;
            fts_pkg::ST_DONE: begin
                if (!r_ov || m_axis_tready) n_state = fts_pkg::ST_IDLE;
            end
            default: n_state = fts_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory port and handshake
    always_comb begin
        s_axis_tready = (r_state == fts_pkg::ST_IDLE);
        n_clr      = r_clr;
        n_tgt      = r_tgt;
        n_rid      = r_rid;
        n_scan     = r_scan;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_running  = r_running;
        n_old_tail = r_old_tail;
        n_link     = r_link;
        n_app_id   = r_app_id;
        n_self     = r_self;
        n_p        = r_p;
        n_n        = r_n;
        n_status   = r_status;
        n_ov       = r_ov && !m_axis_tready;
        n_odata    = r_odata;
        wr_en      = '0;
        wr_addr    = r_tgt;
        wr_data    = '0;
        rd_addr    = r_tgt;

        case (r_state)
            fts_pkg::ST_CLEAR: begin
                wr_en   = '1;
                wr_addr = r_clr;
                n_clr   = r_clr + 1'b1;
            end
            fts_pkg::ST_DISPATCH: begin
                n_status = fts_pkg::STAT_INVALID;
                n_rid    = '0;
                n_self   = 1'b0;
                if (r_kind == fts_pkg::KIND_CREATE) begin
                    rd_addr = IW'(1);
                    n_scan  = IW'(1);
                end else if (r_mode == fts_pkg::MODE_ANY) begin
                    n_tgt = r_head;
                    // empty queue only matters for a valid yield or exit
                    if (r_count == '0 &&
                        (r_kind == fts_pkg::KIND_YIELD || r_kind == fts_pkg::KIND_EXIT))
                        n_status = fts_pkg::STAT_NONE;
                end else if (r_mode == fts_pkg::MODE_SELF) begin
                    n_tgt = r_running;
                end else begin
                    n_tgt   = named_run ? r_running : named_id;
                    rd_addr = named_id;
                end
            end
            fts_pkg::ST_RESOLVED: begin
                n_rid    = r_tgt;
                n_status = fts_pkg::STAT_OK;
                if (r_tgt == r_running) begin
                    if (r_kind == fts_pkg::KIND_EXIT) begin
                        if (r_count == '0) begin
                            n_status = fts_pkg::STAT_NONE;
                            n_rid    = '0;
                        end
                        n_self = 1'b1;
                        n_tgt  = r_head;
                    end
                end else begin
                    n_app_id = r_running;
                end
            end
            fts_pkg::ST_SCAN: begin
                if (!r_rd.in_use) begin
                    n_app_id = r_scan;
                    n_rid    = r_scan;
                    n_status = fts_pkg::STAT_OK;
                end else if (32'(r_scan) == MAX_THREADS - 1) begin
                    n_status = fts_pkg::STAT_NOFREE;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    rd_addr = r_scan + 1'b1;
                end
            end
            fts_pkg::ST_APPEND: begin
                wr_addr        = r_app_id;
                wr_en.in_use   = (r_kind == fts_pkg::KIND_CREATE);
                wr_en.in_q     = 1'b1;
                wr_en.nxt      = 1'b1;
                wr_en.prv      = 1'b1;
                wr_data.in_use = 1'b1;
                wr_data.in_q   = 1'b1;
                wr_data.prv    = r_tail;
                n_old_tail     = r_tail;
                n_link         = (r_count != '0);
                n_tail         = r_app_id;
                if (r_count == '0) n_head = r_app_id;
                n_count        = r_count + 1'b1;
            end
            fts_pkg::ST_LINK_TAIL: begin
                wr_addr     = r_old_tail;
                wr_en.nxt   = r_link;
                wr_data.nxt = r_app_id;
            end
            fts_pkg::ST_UNLINK_RD: begin
                rd_addr = r_tgt;
            end
            fts_pkg::ST_UNLINK_DATA: begin
                n_p = r_rd.prv;
                n_n = r_rd.nxt;
            end
            fts_pkg::ST_FIX_NEXT: begin
                if (r_head == r_tgt) begin
                    n_head = r_n;
                end else begin
                    wr_addr     = r_p;
                    wr_en.nxt   = 1'b1;
                    wr_data.nxt = r_n;
                end
            end
            fts_pkg::ST_FIX_PREV: begin
                if (r_tail == r_tgt) begin
                    n_tail = r_p;
                end else begin
                    wr_addr     = r_n;
                    wr_en.prv   = 1'b1;
                    wr_data.prv = r_p;
                end
            end
            fts_pkg::ST_DROP: begin
                wr_addr      = r_tgt;
                wr_en.in_q   = 1'b1;
                wr_en.in_use = (r_kind == fts_pkg::KIND_EXIT) && !r_self;
                n_count      = r_count - 1'b1;
                if (r_count == (IW+1)'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end
                if (r_kind == fts_pkg::KIND_YIELD) n_running = r_tgt;
            end
            fts_pkg::ST_FREE: begin
                wr_addr      = r_running;
                wr_en.in_use = 1'b1;
                n_running    = r_tgt;
            end
            fts_pkg::ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_odata = {2'b00, IDB'(r_running), IDB'(r_rid), r_status};
                end
            end
            default: begin
                n_ov = r_ov && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fts_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_running <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_running <= n_running;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= s_axis_tdata[1:0];
            r_mode  <= s_axis_tdata[3:2];
            r_named <= s_axis_tdata[13:4];
        end
        r_tgt      <= n_tgt;
        r_rid      <= n_rid;
        r_scan     <= n_scan;
        r_old_tail <= n_old_tail;
        r_link     <= n_link;
        r_app_id   <= n_app_id;
        r_self     <= n_self;
        r_p        <= n_p;
        r_n        <= n_n;
        r_status   <= n_status;
        r_odata    <= n_odata;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

`include "fifo_thread_scheduler_assert.svh"

    `FTS_ASSERT_NOW(a_empty_ptrs, r_state == fts_pkg::ST_IDLE && r_count == '0, r_head == '0 && r_tail == '0, "empty queue with live pointers")
    `FTS_ASSERT_NOW(a_count_max, 1'b1, 32'(r_count) < MAX_THREADS, "queue count overflow")
    `FTS_ASSERT_NEXT(a_busy_after_accept, accept, r_state == fts_pkg::ST_DISPATCH, "accept did not start a command")
    `FTS_ASSERT_NOW(a_no_write_idle, r_state == fts_pkg::ST_IDLE, !wr_any, "memory written while idle")

endmodule

### tb/sv/fifo_thread_scheduler_tb.sv
`timescale 1ns / 100ps

// Scheduler state tracking and result comparison.
class sched_scoreboard;
    localparam int N_IDS = 1024;

    bit                           id_used [N_IDS];
    bit                           queued  [N_IDS];
    logic [fts_pkg::ID_BITS-1:0]  nxt     [N_IDS];
    logic [fts_pkg::ID_BITS-1:0]  prv     [N_IDS];
    logic [fts_pkg::ID_BITS-1:0]  head, tail, run_id;
    int                           qcount;
    logic [23:0]                  pending[$];
    int                           errors;
    int                           n_checked;
    int                           status_seen[4];

    function void clear();
        foreach (id_used[i]) begin
            id_used[i] = 0;
            queued[i]  = 0;
            nxt[i]     = '0;
            prv[i]     = '0;
        end
        head = '0;
        tail = '0;
        run_id = '0;
        qcount = 0;
    endfunction

    function void push_back_id(logic [fts_pkg::ID_BITS-1:0] id);
        queued[id] = 1;
        nxt[id] = '0;
        prv[id] = tail;
        if (qcount == 0) begin
            head = id;
        end else begin
            nxt[tail] = id;
        end
        tail = id;
        qcount++;
    endfunction

    function void unlink_id(logic [fts_pkg::ID_BITS-1:0] id);
        logic [fts_pkg::ID_BITS-1:0] p, n;
        p = prv[id];
        n = nxt[id];
        if (head == id) begin
            head = n;
        end else begin
            nxt[p] = n;
        end
        if (tail == id) begin
            tail = p;
        end else begin
            prv[n] = p;
        end
        queued[id] = 0;
        qcount--;
        if (qcount == 0) begin
            head = '0;
            tail = '0;
        end
    endfunction

    // Apply one accepted command and queue its expected result.
    function void note_command(logic [15:0] cmd);
        logic [1:0]                  kind, mode, st;
        logic [fts_pkg::ID_BITS-1:0] named, rid, tgt;
        bit                          have;
        kind  = cmd[1:0];
        mode  = cmd[3:2];
        named = cmd[13:4];
        st    = fts_pkg::STAT_INVALID;
        rid   = '0;
        tgt   = '0;
        have  = 0;
        if (kind == fts_pkg::KIND_CREATE) begin
            st = fts_pkg::STAT_NOFREE;
            for (int i = 1; i < N_IDS; i++) begin
                if (!id_used[i]) begin
                    id_used[i] = 1;
                    push_back_id(i[fts_pkg::ID_BITS-1:0]);
                    st  = fts_pkg::STAT_OK;
                    rid = i[fts_pkg::ID_BITS-1:0];
                    break;
                end
            end
        end else if (kind == fts_pkg::KIND_YIELD || kind == fts_pkg::KIND_EXIT) begin
            if (mode == fts_pkg::MODE_ANY) begin
                if (qcount == 0) begin
                    st = fts_pkg::STAT_NONE;
                end else begin
                    tgt = head;
                    have = 1;
                end
            end else if (mode == fts_pkg::MODE_SELF) begin
                tgt = run_id;
                have = 1;
            end else if (mode == fts_pkg::MODE_NAMED) begin
                if (named == run_id || queued[named]) begin
                    tgt = named;
                    have = 1;
                end
            end
            if (have && kind == fts_pkg::KIND_YIELD) begin
                st  = fts_pkg::STAT_OK;
                rid = tgt;
                if (tgt != run_id) begin
                    push_back_id(run_id);
                    unlink_id(tgt);
                    run_id = tgt;
                end
            end else if (have) begin
                if (tgt == run_id) begin
                    if (qcount == 0) begin
                        st = fts_pkg::STAT_NONE;
                    end else begin
                        logic [fts_pkg::ID_BITS-1:0] h;
                        h = head;
                        unlink_id(h);
                        id_used[run_id] = 0;
                        run_id = h;
                        st  = fts_pkg::STAT_OK;
                        rid = tgt;
                    end
                end else begin
                    unlink_id(tgt);
                    id_used[tgt] = 0;
                    st  = fts_pkg::STAT_OK;
                    rid = tgt;
                end
            end
        end
        status_seen[st]++;
        pending.push_back({2'b00, run_id, rid, st});
    endfunction

    function void check_result(logic [23:0] got);
        logic [23:0] exp;
        n_checked++;
        if (pending.size() == 0) begin
            $error("result with no command pending: %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got[1:0] !== exp[1:0]) begin
            $error("status: expected %0d, got %0d", exp[1:0], got[1:0]);
            errors++;
        end
        if (got[11:2] !== exp[11:2]) begin
            $error("result_id: expected %0d, got %0d", exp[11:2], got[11:2]);
            errors++;
        end
        if (got[21:12] !== exp[21:12]) begin
            $error("running_id: expected %0d, got %0d", exp[21:12], got[21:12]);
            errors++;
        end
        if (got[23:22] !== 2'b00) begin
            $error("pad bits: expected 0, got %0d", got[23:22]);
            errors++;
        end
    endfunction
endclass

module fifo_thread_scheduler_tb;

    localparam int N_RANDOM = 760;
    localparam int DRAIN_CYCLES = 2000;   // worst create scan plus slack

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [1:0] kind, [3:2] target_mode, [13:4] target_id, [15:14] zero
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [1:0] status, [11:2] result_id, [21:12] running_id, [23:22] zero
    logic [23:0] m_axis_tdata;

    sched_scoreboard sb;
    bit              hold_off;     // receiver parks for a long stretch
    int              n_sent;

    fifo_thread_scheduler uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // True once every id from 1 up is in use.
    function automatic bit table_full();
        for (int k = 1; k < 1024; k++) begin
            if (!sb.id_used[k]) return 0;
        end
        return 1;
    endfunction

    // Offer one command; hold tdata until accepted, then maybe idle.
    // In burst mode the valid stays high back to back with no gaps.
    task automatic send_cmd(logic [1:0] kind, logic [1:0] mode, logic [9:0] id,
                            bit burst);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, id, mode, kind};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(s_axis_tdata);
        n_sent++;
        g = burst ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom) & 16'h3fff;   // garbage while idle
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Pick an id that is live: running or queued, per current predicted state.
    function automatic logic [9:0] live_id();
        logic [9:0] c;
        if (sb.qcount == 0 || $urandom_range(3) == 0) return sb.run_id;
        for (int k = 0; k < 50; k++) begin
            c = 10'($urandom_range(63));
            if (sb.queued[c]) return c;
        end
        return sb.head;
    endfunction

    // Random command mix biased toward well-formed traffic over few ids.
    task automatic send_random(bit burst);
        int         r;
        logic [1:0] kind, mode;
        logic [9:0] id;
        r    = $urandom_range(99);
        kind = (r < 30) ? fts_pkg::KIND_CREATE : (r < 62) ? fts_pkg::KIND_YIELD :
               (r < 96) ? fts_pkg::KIND_EXIT : 2'd3;
        r    = $urandom_range(99);
        mode = (r < 30) ? fts_pkg::MODE_ANY : (r < 50) ? fts_pkg::MODE_SELF :
               (r < 97) ? fts_pkg::MODE_NAMED : 2'd3;
        r    = $urandom_range(99);
        if (r < 70)      id = live_id();
        else if (r < 90) id = 10'($urandom_range(63));
        else             id = 10'($urandom_range(1023));
        // keep creates from bursting the table on every call
        if (kind == fts_pkg::KIND_CREATE && sb.qcount > 40) kind = fts_pkg::KIND_EXIT;
        send_cmd(kind, mode, id, burst);
    endtask

    // Receiver: random stalls, plus a long park when hold_off is set.
    initial begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    initial begin
        int   quiet;
        sb = new();
        sb.clear();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-queue cases, invalid codes, id extremes.
        send_cmd(fts_pkg::KIND_YIELD, fts_pkg::MODE_ANY,   10'd0,    0);  // none available
        send_cmd(fts_pkg::KIND_EXIT,  fts_pkg::MODE_ANY,   10'd0,    0);  // none available
        send_cmd(fts_pkg::KIND_EXIT,  fts_pkg::MODE_SELF,  10'd0,    0);  // self exit, empty
        send_cmd(fts_pkg::KIND_YIELD, fts_pkg::MODE_SELF,  10'd0,    0);  // yield to self
        send_cmd(fts_pkg::KIND_YIELD, fts_pkg::MODE_NAMED, 10'd1023, 0);  // unknown id
        send_cmd(fts_pkg::KIND_EXIT,  fts_pkg::MODE_NAMED, 10'd0,    0);  // named running
        send_cmd(2'd3,                fts_pkg::MODE_ANY,   10'd5,    0);  // bad kind
        send_cmd(fts_pkg::KIND_YIELD, 2'd3,                10'd0,    0);  // bad mode
        send_cmd(fts_pkg::KIND_CREATE, fts_pkg::MODE_ANY,   10'h3ff, 0);
        send_cmd(fts_pkg::KIND_CREATE, 2'd3,                10'h2aa, 0);
        send_cmd(fts_pkg::KIND_CREATE, fts_pkg::MODE_NAMED, 10'h155, 0);
        send_cmd(fts_pkg::KIND_YIELD, fts_pkg::MODE_ANY,   10'd0,    0);  // run 1
        send_cmd(fts_pkg::KIND_YIELD, fts_pkg::MODE_NAMED, 10'd0,    0);  // back to 0
        send_cmd(fts_pkg::KIND_YIELD, fts_pkg::MODE_NAMED, 10'd0,    0);  // named running id
        send_cmd(fts_pkg::KIND_EXIT,  fts_pkg::MODE_ANY,   10'd0,    0);  // frees head
        send_cmd(fts_pkg::KIND_EXIT,  fts_pkg::MODE_NAMED, 10'd3,    0);  // queued id
        send_cmd(fts_pkg::KIND_EXIT,  fts_pkg::MODE_NAMED, 10'd3,    0);  // now invalid
        send_cmd(fts_pkg::KIND_CREATE, fts_pkg::MODE_ANY,  10'd0,    0);  // reuses lowest
        send_cmd(fts_pkg::KIND_EXIT,  fts_pkg::MODE_SELF,  10'd0,    0);  // starts head

        // Table-full: fill every id, one create more, then drain part way.
        while (!table_full()) send_cmd(fts_pkg::KIND_CREATE, fts_pkg::MODE_ANY, 10'd0, 1);
        send_cmd(fts_pkg::KIND_CREATE, fts_pkg::MODE_ANY, 10'd0, 0);      // no free id
        send_cmd(fts_pkg::KIND_YIELD, fts_pkg::MODE_NAMED, 10'd1023, 0);
        send_cmd(fts_pkg::KIND_EXIT,  fts_pkg::MODE_NAMED, 10'd512, 0);
        send_cmd(fts_pkg::KIND_CREATE, fts_pkg::MODE_ANY, 10'd0, 0);      // refills 512
        repeat (100) send_cmd(fts_pkg::KIND_EXIT, fts_pkg::MODE_ANY, 10'd0, 1);

        // Random part; long receiver stall with the sender bursting mid-run.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) hold_off = 1;
            send_random(i >= N_RANDOM / 3 && i < N_RANDOM / 3 + 20);
        end
        s_axis_tvalid <= 1'b0;

        quiet = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        while (quiet < DRAIN_CYCLES) begin
            @(posedge i_clk);
            quiet++;
        end
        $display("%0d commands, %0d results; status ok/none/invalid/nofree = %0d/%0d/%0d/%0d",
                 n_sent, sb.n_checked, sb.status_seen[0], sb.status_seen[1],
                 sb.status_seen[2], sb.status_seen[3]);
        $display("covered empty-queue, full-table, invalid-id and long output stall");
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #40_000_000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
